// ===== rtl/csk_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types for the cosine top-k search block.
// No dependencies; imported by cosine_top_k_search.
package csk_pkg;

   localparam int CSK_MAX_ROWS = 256;
   localparam int CSK_MAX_DIM  = 512;
   localparam int CSK_MAX_TOP  = 64;

   localparam logic [1:0] MODE_DOC   = 2'd0;
   localparam logic [1:0] MODE_CHUNK = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;

   localparam logic [1:0] CSR_ROWS  = 2'd0;
   localparam logic [1:0] CSR_DIM   = 2'd1;
   localparam logic [1:0] CSR_LIMIT = 2'd2;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_DOT   = 11'b000_0000_0010,
      ST_DRAIN = 11'b000_0000_0100,
      ST_SQ    = 11'b000_0000_1000,
      ST_RADD  = 11'b000_0001_0000,
      ST_RCMP  = 11'b000_0010_0000,
      ST_RRD   = 11'b000_0100_0000,
      ST_RCMP2 = 11'b000_1000_0000,
      ST_ERD   = 11'b001_0000_0000,
      ST_EWAIT = 11'b010_0000_0000,
      ST_EBAD  = 11'b100_0000_0000
   } csk_state_type;

   typedef struct packed {
      logic [7:0]  row;
      logic [30:0] chunk;
      logic [16:0] score;
   } csk_hit_type;

endpackage

// ===== rtl/cosine_top_k_search.sv =====
`timescale 1ns / 1ps
// Cosine similarity top-k search over a document store held in on-chip memory.
// Depends on csk_pkg for codes, the state type and the hit record.
//
// Usage:
//   req_* carries load and query items (valid/stall). Mode 0 writes one document
//   element, mode 1 a chunk id, mode 2 one query element. Load items and query
//   elements are accepted back to back while req_stall is low. The query element
//   with req_query_last set starts a search; req_stall stays high until the search
//   has placed its last result in the output register.
//   Search steps: per row, a dot product over the dimension (one memory read pair
//   per cycle), then squaring and the bit-by-bit score root, then insertion, which
//   walks at most top_k ranked entries. Results then leave one by one, each entry
//   read (ST_ERD) and then loaded (ST_EWAIT) while rsp_stall is low.
//   rsp_* carries hits (valid/stall); a stalled hit holds until taken, and the
//   output register lets the next search start while the final hit waits.
//   csr_* writes the three registers; csr_ready is always high. Write them only
//   while no search is running.
//   Reset clears rows, sets dimension and limit to 1, clears query count, energy
//   and ranking; doc, chunk and query memories are not cleared, need no clearing pass.
module cosine_top_k_search
   import csk_pkg::*;
#(
   parameter int MAX_ROWS = CSK_MAX_ROWS,
   parameter int MAX_DIM  = CSK_MAX_DIM,
   parameter int MAX_TOP  = CSK_MAX_TOP
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_row_index,
   input  logic [8:0]  req_column_index,
   input  logic signed [15:0] req_element_value,
   input  logic [30:0] req_chunk_value,
   input  logic        req_query_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit_valid,
   output logic [7:0]  rsp_hit_row,
   output logic [30:0] rsp_hit_chunk,
   output logic signed [16:0] rsp_hit_score,
   output logic        rsp_hit_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_data
);

   localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int RCW = $clog2(MAX_ROWS + 1);
   localparam int QW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int QCW = $clog2(MAX_DIM + 2);
   localparam int DAW = (MAX_ROWS * MAX_DIM > 1) ? $clog2(MAX_ROWS * MAX_DIM) : 1;
   localparam int EW  = $clog2(MAX_DIM) + 31;
   localparam int H   = (EW + 1) / 2;
   localparam int AW  = 2 * EW + 2;
   localparam int TW  = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1;
   localparam int TCW = $clog2(MAX_TOP + 1);

   // memories
   logic signed [15:0] doc_mem   [MAX_ROWS * MAX_DIM];
   logic [30:0]        chunk_mem [MAX_ROWS];
   logic signed [15:0] q_mem     [MAX_DIM];
   csk_hit_type        rk_mem    [MAX_TOP];

   csk_state_type state_ff;
   logic [8:0]    rows_cfg_ff;
   logic [9:0]    dim_cfg_ff;
   logic [6:0]    lim_cfg_ff;
   logic [QCW-1:0] qcnt_ff, qcnt_in;
   logic [EW-1:0]  energy_ff, energy_in, srch_e_ff;
   logic [RW-1:0]  r_ff;
   logic [DAW-1:0] base_ff;
   logic [QW-1:0]  i_ff;
   logic           rd_v_ff, prod_v_ff;
   logic signed [15:0] d_q, q_q;
   logic signed [31:0] prod_ff;
   logic signed [EW:0] acc_ff;
   logic [30:0]    chunk_q;
   logic [1:0]     sq_k_ff;
   logic [2*H-1:0] mul_ff;
   logic [AW-1:0]  d2_ff, a_ff, t_ff, es2_ff, cand_ff;
   logic [15:0]    mask_ff, s_ff;
   logic [TCW-1:0] rank_cnt_ff, pos_ff, e_ff;
   csk_hit_type    rk_q;
   logic           rsp_valid_ff, rsp_hit_valid_ff, rsp_hit_last_ff;
   logic [7:0]     rsp_hit_row_ff;
   logic [30:0]    rsp_hit_chunk_ff;
   logic [16:0]    rsp_hit_score_ff;

   logic           req_acc, is_query, search_ok, out_free, accept_bit, rsp_load;
   logic [RCW-1:0] rows_eff;
   logic [TCW-1:0] lim_eff;
   logic [EW-1:0]  mag;
   logic [H-1:0]   mag_lo, mag_hi, mul_a, mul_b;
   logic signed [31:0] sq32;
   logic [DAW-1:0] doc_waddr, doc_raddr;
   logic           doc_we;
   csk_hit_type    hit_cur, rk_wdata;
   logic           cmp_before, do_place, do_shift, rk_we;
   logic [TW-1:0]  rk_waddr, rk_raddr;
   logic [TCW-1:0] pos_dec;
   logic [16:0]    s_ext;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_acc   = req_valid && !req_stall;
   assign is_query  = (req_mode == MODE_QUERY);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = ((state_ff == ST_EWAIT) || (state_ff == ST_EBAD)) && out_free;

   assign rows_eff = RCW'((32'(rows_cfg_ff) > MAX_ROWS) ? MAX_ROWS : 32'(rows_cfg_ff));
   assign lim_eff  = TCW'((32'(lim_cfg_ff) > MAX_TOP) ? MAX_TOP : 32'(lim_cfg_ff));

   // query count saturates one past the store so an overlong query fails the check
   assign sq32 = req_element_value * req_element_value;
   always_comb begin
      if (32'(qcnt_ff) < MAX_DIM) begin
         qcnt_in   = qcnt_ff + 1'b1;
         energy_in = energy_ff + EW'($unsigned(sq32));
      end else begin
         qcnt_in   = QCW'(MAX_DIM + 1);
         energy_in = energy_ff;
      end
   end

   assign search_ok = (rows_eff != '0) && (lim_eff != '0) && (32'(dim_cfg_ff) <= MAX_DIM)
                    && (32'(qcnt_in) == 32'(dim_cfg_ff)) && (energy_in != '0);

   assign doc_we    = req_acc && (req_mode == MODE_DOC) && (32'(req_row_index) < MAX_ROWS)
                    && (32'(req_column_index) < MAX_DIM);
   assign doc_waddr = DAW'(32'(req_row_index) * MAX_DIM + 32'(req_column_index));
   assign doc_raddr = base_ff + DAW'(i_ff);

   always_ff @(posedge clock) begin
      if (doc_we) begin
         doc_mem[doc_waddr] <= req_element_value;
      end
      d_q <= doc_mem[doc_raddr];
   end

   always_ff @(posedge clock) begin
      if (req_acc && (req_mode == MODE_CHUNK) && (32'(req_row_index) < MAX_ROWS)) begin
         chunk_mem[RW'(req_row_index)] <= req_chunk_value;
      end
      chunk_q <= chunk_mem[r_ff];
   end

   always_ff @(posedge clock) begin
      if (req_acc && is_query && (32'(qcnt_ff) < MAX_DIM)) begin
         q_mem[qcnt_ff[QW-1:0]] <= req_element_value;
      end
      q_q <= q_mem[i_ff];
   end

   // squaring operands: low*low, high*low, high*high
   assign mag    = acc_ff[EW] ? EW'(-acc_ff) : acc_ff[EW-1:0];
   assign mag_lo = mag[H-1:0];
   assign mag_hi = H'(mag >> H);
   always_comb begin
      case (sq_k_ff)
         2'd0:    begin mul_a = mag_lo; mul_b = mag_lo; end
         2'd1:    begin mul_a = mag_hi; mul_b = mag_lo; end
         default: begin mul_a = mag_hi; mul_b = mag_hi; end
      endcase
   end

   assign accept_bit = (cand_ff <= d2_ff);

   // ranking
   assign s_ext         = {1'b0, s_ff};
   assign hit_cur.row   = 8'(r_ff);
   assign hit_cur.chunk = chunk_q;
   assign hit_cur.score = acc_ff[EW] ? -s_ext : s_ext;
   assign cmp_before = ($signed(hit_cur.score) > $signed(rk_q.score))
                    || ((hit_cur.score == rk_q.score) && (hit_cur.chunk < rk_q.chunk));
   assign do_place = ((state_ff == ST_RRD) && (pos_ff == '0))
                  || ((state_ff == ST_RCMP2) && !cmp_before);
   assign do_shift = (state_ff == ST_RCMP2) && cmp_before;
   assign rk_we    = (do_place || do_shift) && (pos_ff < lim_eff);
   assign rk_wdata = do_shift ? rk_q : hit_cur;
   assign rk_waddr = pos_ff[TW-1:0];
   assign pos_dec  = pos_ff - 1'b1;
   assign rk_raddr = (state_ff == ST_RRD) ? pos_dec[TW-1:0] : e_ff[TW-1:0];

   always_ff @(posedge clock) begin
      if (rk_we) begin
         rk_mem[rk_waddr] <= rk_wdata;
      end
      rk_q <= rk_mem[rk_raddr];
   end

   always_ff @(posedge clock) begin
      prod_ff <= q_q * d_q;
      mul_ff  <= mul_a * mul_b;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_cfg_ff  <= '0;
         dim_cfg_ff   <= 10'd1;
         lim_cfg_ff   <= 7'd1;
         qcnt_ff      <= '0;
         energy_ff    <= '0;
         rd_v_ff      <= 1'b0;
         prod_v_ff    <= 1'b0;
         rank_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROWS:  rows_cfg_ff <= csr_data[8:0];
               CSR_DIM:   dim_cfg_ff  <= csr_data;
               CSR_LIMIT: lim_cfg_ff  <= csr_data[6:0];
               default:   ;
            endcase
         end
         rd_v_ff   <= (state_ff == ST_DOT);
         prod_v_ff <= rd_v_ff;
         if (prod_v_ff) begin
            acc_ff <= acc_ff + (EW+1)'(prod_ff);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (do_place && (pos_ff < lim_eff) && (rank_cnt_ff < lim_eff)) begin
            rank_cnt_ff <= rank_cnt_ff + 1'b1;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_acc && is_query && req_query_last) begin
                  qcnt_ff     <= '0;
                  energy_ff   <= '0;
                  srch_e_ff   <= energy_in;
                  rank_cnt_ff <= '0;
                  if (search_ok) begin
                     r_ff        <= '0;
                     base_ff     <= '0;
                     i_ff        <= '0;
                     acc_ff      <= '0;
                     state_ff    <= ST_DOT;
                  end else begin
                     state_ff <= ST_EBAD;
                  end
               end else if (req_acc && is_query) begin
                  qcnt_ff   <= qcnt_in;
                  energy_ff <= energy_in;
               end
            end
            ST_DOT: begin
               if (32'(i_ff) == 32'(dim_cfg_ff) - 1) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  i_ff <= i_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               if (!rd_v_ff && !prod_v_ff) begin
                  sq_k_ff  <= 2'd0;
                  state_ff <= ST_SQ;
               end
            end
            ST_SQ: begin
               sq_k_ff <= sq_k_ff + 1'b1;
               case (sq_k_ff)
                  2'd0: d2_ff <= '0;
                  2'd1: d2_ff <= d2_ff + AW'(mul_ff);
                  2'd2: d2_ff <= d2_ff + (AW'(mul_ff) << (H + 1));
                  default: begin
                     d2_ff    <= d2_ff + (AW'(mul_ff) << (2 * H));
                     a_ff     <= '0;
                     t_ff     <= '0;
                     es2_ff   <= AW'(srch_e_ff) << 30;
                     mask_ff  <= 16'h8000;
                     s_ff     <= '0;
                     state_ff <= ST_RADD;
                  end
               endcase
            end
            ST_RADD: begin
               // trial (s + 2^b)^2 * E = A + s*E*2^(b+1) + E*2^(2b)
               cand_ff  <= a_ff + t_ff + es2_ff;
               state_ff <= ST_RCMP;
            end
            ST_RCMP: begin
               if (accept_bit) begin
                  a_ff <= cand_ff;
                  s_ff <= s_ff | mask_ff;
                  t_ff <= (t_ff + (es2_ff << 1)) >> 1;
               end else begin
                  t_ff <= t_ff >> 1;
               end
               es2_ff  <= es2_ff >> 2;
               mask_ff <= mask_ff >> 1;
               if ((accept_bit && mask_ff[15]) || mask_ff[0]) begin
                  pos_ff   <= rank_cnt_ff;
                  state_ff <= ST_RRD;
               end else begin
                  state_ff <= ST_RADD;
               end
            end
            ST_RRD, ST_RCMP2: begin
               if (do_shift) begin
                  pos_ff   <= pos_dec;
                  state_ff <= ST_RRD;
               end else if (do_place) begin
                  if (32'(r_ff) + 1 < 32'(rows_eff)) begin
                     r_ff     <= r_ff + 1'b1;
                     base_ff  <= base_ff + DAW'(MAX_DIM);
                     i_ff     <= '0;
                     acc_ff   <= '0;
                     state_ff <= ST_DOT;
                  end else begin
                     e_ff     <= '0;
                     state_ff <= ST_ERD;
                  end
               end else begin
                  state_ff <= ST_RCMP2;
               end
            end
            ST_ERD: begin
               state_ff <= ST_EWAIT;
            end
            ST_EWAIT: begin
               if (out_free) begin
                  rsp_hit_valid_ff <= 1'b1;
                  rsp_hit_row_ff   <= rk_q.row;
                  rsp_hit_chunk_ff <= rk_q.chunk;
                  rsp_hit_score_ff <= rk_q.score;
                  rsp_hit_last_ff  <= (e_ff + 1'b1 == rank_cnt_ff);
                  if (e_ff + 1'b1 == rank_cnt_ff) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     e_ff     <= e_ff + 1'b1;
                     state_ff <= ST_ERD;
                  end
               end
            end
            ST_EBAD: begin
               if (out_free) begin
                  rsp_hit_valid_ff <= 1'b0;
                  rsp_hit_row_ff   <= '0;
                  rsp_hit_chunk_ff <= '0;
                  rsp_hit_score_ff <= '0;
                  rsp_hit_last_ff  <= 1'b1;
                  state_ff         <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit_valid = rsp_hit_valid_ff;
   assign rsp_hit_row   = rsp_hit_row_ff;
   assign rsp_hit_chunk = rsp_hit_chunk_ff;
   assign rsp_hit_score = rsp_hit_score_ff;
   assign rsp_hit_last  = rsp_hit_last_ff;

   a_rank_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (rank_cnt_ff <= lim_eff))
      else $error("ranking holds more entries than the limit");
   a_pos: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RRD) || (state_ff == ST_RCMP2)) |-> (pos_ff <= rank_cnt_ff))
      else $error("insertion position beyond ranked count");
   a_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RADD) |-> !s_ff[15])
      else $error("root search continued past full scale");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit_valid) |-> rsp_hit_last)
      else $error("empty result not marked last");

endmodule
